/* rtl/core/dbfb_pkg.sv */
package dbfb_pkg;

  localparam int BCH1_LEN     = 22;
  localparam int BCH2_LEN     = 13;
  localparam int D1_LEN       = 61;
  localparam int D2_LEN       = 26;
  localparam int BCH1_STEPS   = D1_LEN + BCH1_LEN - 1;
  localparam int BCH2_STEPS   = D2_LEN + BCH2_LEN - 1;
  localparam int STEP_W       = $clog2(BCH1_STEPS);
  localparam int PREAMBLE_LEN = 15;
  localparam int SYNC_LEN     = 9;
  localparam int FRAME_BITS   = 144;
  localparam int FRAME_BYTES  = FRAME_BITS / 8;
  localparam int IDX_W        = 5;
  localparam int ADDR_W       = 5;
  localparam int DATA_W       = 32;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [SYNC_LEN-1:0] SYNC_NORMAL = 9'b000101111;
  localparam logic [SYNC_LEN-1:0] SYNC_TEST   = 9'b011010000;

  localparam logic [1:0] PROTO_USER = 2'd0;
  localparam logic [1:0] PROTO_STD  = 2'd1;

  localparam logic [1:0] KIND_EPIRB = 2'd0;
  localparam logic [1:0] KIND_PLB   = 2'd1;

  localparam logic [2:0] USER_EPIRB = 3'b010;
  localparam logic [2:0] USER_PLB   = 3'b011;
  localparam logic [2:0] USER_ELT   = 3'b001;
  localparam logic [2:0] USER_PLB_SERIAL = 3'b110;
  localparam logic [3:0] STD_EPIRB  = 4'b0010;
  localparam logic [3:0] STD_PLB    = 4'b0111;
  localparam logic [3:0] STD_ELT    = 4'b0011;
  localparam logic [3:0] NAT_EPIRB  = 4'b1010;
  localparam logic [3:0] NAT_PLB    = 4'b1011;
  localparam logic [3:0] NAT_ELT    = 4'b1000;
  localparam logic [3:0] FIELD2_HEAD = 4'b1101;

  localparam logic [1:0]          PROTO_RESET     = PROTO_STD;
  localparam logic [BCH1_LEN-1:0] BCH1_POLY_RESET = 22'd2546147;
  localparam logic [BCH2_LEN-1:0] BCH2_POLY_RESET = 13'd5433;

  typedef enum logic [2:0] {
    REG_PROTOCOL_MODE,
    REG_BEACON_KIND,
    REG_COUNTRY_CODE,
    REG_TEST_FRAME,
    REG_INTERNAL_NAV,
    REG_HOMING_121,
    REG_BCH1_POLY,
    REG_BCH2_POLY
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]          protocol_mode;
    logic [1:0]          beacon_kind;
    logic [9:0]          country_code;
    logic                test_frame;
    logic                internal_nav;
    logic                homing_121;
    logic [BCH1_LEN-1:0] bch1_poly;
    logic [BCH2_LEN-1:0] bch2_poly;
  } cfg_t;

  typedef struct packed {
    logic [SYNC_LEN-1:0] sync;
    logic [D1_LEN-1:0]   field1;
    logic [D2_LEN-1:0]   field2;
  } entry_t;

  // quotient in [6:4], remainder in [3:0]
  function automatic logic [6:0] div15(input logic [5:0] m);
    logic [2:0] q;
    logic [5:0] r;
    begin
      if (m >= 6'd60) begin
        q = 3'd4;
        r = m - 6'd60;
      end else if (m >= 6'd45) begin
        q = 3'd3;
        r = m - 6'd45;
      end else if (m >= 6'd30) begin
        q = 3'd2;
        r = m - 6'd30;
      end else if (m >= 6'd15) begin
        q = 3'd1;
        r = m - 6'd15;
      end else begin
        q = 3'd0;
        r = m;
      end
      div15 = {q, r[3:0]};
    end
  endfunction

  function automatic logic [BCH1_LEN-1:0] bch1_step(input logic [BCH1_LEN-1:0] r,
                                                    input logic [BCH1_LEN-1:0] poly,
                                                    input logic                din);
    logic [BCH1_LEN-1:0] t;
    begin
      t = r[BCH1_LEN-1] ? (r ^ poly) : r;
      bch1_step = {t[BCH1_LEN-2:0], din};
    end
  endfunction

  function automatic logic [BCH1_LEN-2:0] bch1_rem(input logic [BCH1_LEN-1:0] r,
                                                   input logic [BCH1_LEN-1:0] poly);
    logic [BCH1_LEN-1:0] t;
    begin
      t = r[BCH1_LEN-1] ? (r ^ poly) : r;
      bch1_rem = t[BCH1_LEN-2:0];
    end
  endfunction

  function automatic logic [BCH2_LEN-1:0] bch2_step(input logic [BCH2_LEN-1:0] r,
                                                    input logic [BCH2_LEN-1:0] poly,
                                                    input logic                din);
    logic [BCH2_LEN-1:0] t;
    begin
      t = r[BCH2_LEN-1] ? (r ^ poly) : r;
      bch2_step = {t[BCH2_LEN-2:0], din};
    end
  endfunction

  function automatic logic [BCH2_LEN-2:0] bch2_rem(input logic [BCH2_LEN-1:0] r,
                                                   input logic [BCH2_LEN-1:0] poly);
    logic [BCH2_LEN-1:0] t;
    begin
      t = r[BCH2_LEN-1] ? (r ^ poly) : r;
      bch2_rem = t[BCH2_LEN-2:0];
    end
  endfunction

endpackage

/* rtl/core/dbfb_regs.sv */
module dbfb_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dbfb_pkg::ADDR_W-1:0] paddr,
  input  logic [dbfb_pkg::DATA_W-1:0] pwdata,
  output logic [dbfb_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output dbfb_pkg::cfg_t              cfg
);

  dbfb_pkg::reg_idx_t idx;
  logic               wr;

  assign pready = 1'b1;
  assign idx    = dbfb_pkg::reg_idx_t'(paddr[dbfb_pkg::ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.protocol_mode <= dbfb_pkg::PROTO_RESET;
      cfg.beacon_kind   <= dbfb_pkg::KIND_EPIRB;
      cfg.country_code  <= '0;
      cfg.test_frame    <= 1'b0;
      cfg.internal_nav  <= 1'b0;
      cfg.homing_121    <= 1'b0;
      cfg.bch1_poly     <= dbfb_pkg::BCH1_POLY_RESET;
      cfg.bch2_poly     <= dbfb_pkg::BCH2_POLY_RESET;
    end else if (wr) begin
      unique case (idx)
        dbfb_pkg::REG_PROTOCOL_MODE: cfg.protocol_mode <= pwdata[1:0];
        dbfb_pkg::REG_BEACON_KIND:   cfg.beacon_kind   <= pwdata[1:0];
        dbfb_pkg::REG_COUNTRY_CODE:  cfg.country_code  <= pwdata[9:0];
        dbfb_pkg::REG_TEST_FRAME:    cfg.test_frame    <= pwdata[0];
        dbfb_pkg::REG_INTERNAL_NAV:  cfg.internal_nav  <= pwdata[0];
        dbfb_pkg::REG_HOMING_121:    cfg.homing_121    <= pwdata[0];
        dbfb_pkg::REG_BCH1_POLY:     cfg.bch1_poly     <= pwdata[dbfb_pkg::BCH1_LEN-1:0];
        dbfb_pkg::REG_BCH2_POLY:     cfg.bch2_poly     <= pwdata[dbfb_pkg::BCH2_LEN-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      dbfb_pkg::REG_PROTOCOL_MODE: prdata = dbfb_pkg::DATA_W'(cfg.protocol_mode);
      dbfb_pkg::REG_BEACON_KIND:   prdata = dbfb_pkg::DATA_W'(cfg.beacon_kind);
      dbfb_pkg::REG_COUNTRY_CODE:  prdata = dbfb_pkg::DATA_W'(cfg.country_code);
      dbfb_pkg::REG_TEST_FRAME:    prdata = dbfb_pkg::DATA_W'(cfg.test_frame);
      dbfb_pkg::REG_INTERNAL_NAV:  prdata = dbfb_pkg::DATA_W'(cfg.internal_nav);
      dbfb_pkg::REG_HOMING_121:    prdata = dbfb_pkg::DATA_W'(cfg.homing_121);
      dbfb_pkg::REG_BCH1_POLY:     prdata = dbfb_pkg::DATA_W'(cfg.bch1_poly);
      dbfb_pkg::REG_BCH2_POLY:     prdata = dbfb_pkg::DATA_W'(cfg.bch2_poly);
    endcase
  end

endmodule

/* rtl/core/dbfb_front.sv */
module dbfb_front (
  input  logic             push,
  output logic             full,
  input  logic             south,
  input  logic             west,
  input  logic [6:0]       lat_deg,
  input  logic [5:0]       lat_min,
  input  logic [5:0]       lat_sec,
  input  logic [7:0]       lon_deg,
  input  logic [5:0]       lon_min,
  input  logic [5:0]       lon_sec,
  input  dbfb_pkg::cfg_t   cfg,
  input  logic             q_full,
  output logic             q_wr,
  output dbfb_pkg::entry_t q_data
);

  logic       user;
  logic       stdl;
  logic [2:0] t3;
  logic [3:0] t4;
  logic [6:0] lat_qr;
  logic [6:0] lon_qr;
  logic [8:0] lat_c;
  logic [9:0] lon_c;

  assign full = q_full;
  assign q_wr = push && !q_full;

  assign user   = (cfg.protocol_mode == dbfb_pkg::PROTO_USER);
  assign stdl   = (cfg.protocol_mode == dbfb_pkg::PROTO_STD);
  assign lat_qr = dbfb_pkg::div15(lat_min);
  assign lon_qr = dbfb_pkg::div15(lon_min);
  assign lat_c  = {lat_deg, 2'b00} + 9'(lat_qr[6:4]);
  assign lon_c  = {lon_deg, 2'b00} + 10'(lon_qr[6:4]);

  always_comb begin
    unique case (cfg.beacon_kind)
      dbfb_pkg::KIND_EPIRB: begin
        t3 = dbfb_pkg::USER_EPIRB;
        t4 = stdl ? dbfb_pkg::STD_EPIRB : dbfb_pkg::NAT_EPIRB;
      end
      dbfb_pkg::KIND_PLB: begin
        t3 = dbfb_pkg::USER_PLB;
        t4 = stdl ? dbfb_pkg::STD_PLB : dbfb_pkg::NAT_PLB;
      end
      default: begin
        t3 = dbfb_pkg::USER_ELT;
        t4 = stdl ? dbfb_pkg::STD_ELT : dbfb_pkg::NAT_ELT;
      end
    endcase
  end

  always_comb begin
    q_data.sync = cfg.test_frame ? dbfb_pkg::SYNC_TEST : dbfb_pkg::SYNC_NORMAL;
    priority if (user) begin
      q_data.field1 = {1'b1, 1'b1, cfg.country_code, t3,
                       (cfg.beacon_kind == dbfb_pkg::KIND_PLB) ?
                         dbfb_pkg::USER_PLB_SERIAL : 3'b000,
                       42'd0, cfg.homing_121};
      q_data.field2 = {cfg.internal_nav, south, lat_deg, lat_min[5:2],
                       west, lon_deg, lon_min[5:2]};
    end else if (stdl) begin
      q_data.field1 = {1'b1, 1'b0, cfg.country_code, t4, 24'd0,
                       south, lat_c, west, lon_c};
      q_data.field2 = {dbfb_pkg::FIELD2_HEAD, cfg.internal_nav, cfg.homing_121, 1'b1,
                       {1'b0, lat_qr[3:0]}, lat_sec[5:2], 1'b1,
                       {1'b0, lon_qr[3:0]}, lon_sec[5:2]};
    end else begin
      q_data.field1 = {1'b1, 1'b0, cfg.country_code, t4, 18'd0,
                       south, lat_deg, lat_min[5:1], west, lon_deg, lon_min[5:1]};
      q_data.field2 = {dbfb_pkg::FIELD2_HEAD, cfg.internal_nav, cfg.homing_121, 1'b1,
                       {1'b0, lat_min[0]}, lat_sec[5:2], 1'b1,
                       {1'b0, lon_min[0]}, lon_sec[5:2], 6'd0};
    end
  end

endmodule

/* rtl/core/dbfb_queue.sv */
module dbfb_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  dbfb_pkg::entry_t wr_data,
  output logic             full,
  input  logic             rd,
  output dbfb_pkg::entry_t rd_data,
  output logic             empty
);

  localparam int PTR_W = $clog2(dbfb_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(dbfb_pkg::QUEUE_DEPTH + 1);

  dbfb_pkg::entry_t slots [dbfb_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(dbfb_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PTR_W'(dbfb_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == PTR_W'(dbfb_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wptr] <= wr_data;
    end
  end

endmodule

/* rtl/core/dbfb_back.sv */
module dbfb_back (
  input  logic                       clk,
  input  logic                       rst,
  input  dbfb_pkg::cfg_t             cfg,
  input  logic                       q_empty,
  input  dbfb_pkg::entry_t           q_data,
  output logic                       q_rd,
  input  logic                       pop,
  output logic                       empty,
  output logic [7:0]                 frame_byte,
  output logic [dbfb_pkg::IDX_W-1:0] byte_pos,
  output logic                       last_byte
);

  typedef enum logic [1:0] {
    IDLE,
    CALC,
    FIN,
    EMIT
  } state_t;

  state_t                            state;
  logic [dbfb_pkg::STEP_W-1:0]       cnt;
  logic [dbfb_pkg::SYNC_LEN-1:0]     sync;
  logic [dbfb_pkg::D1_LEN-1:0]       field1;
  logic [dbfb_pkg::D2_LEN-1:0]       field2;
  logic [dbfb_pkg::D1_LEN-1:0]       sh1;
  logic [dbfb_pkg::D2_LEN-1:0]       sh2;
  logic [dbfb_pkg::BCH1_LEN-1:0]     r1;
  logic [dbfb_pkg::BCH2_LEN-1:0]     r2;
  logic [dbfb_pkg::FRAME_BITS-1:0]   frame;
  logic [dbfb_pkg::IDX_W-1:0]        idx;

  assign q_rd       = (state == IDLE) && !q_empty;
  assign empty      = (state != EMIT);
  assign frame_byte = frame[dbfb_pkg::FRAME_BITS-1 -: 8];
  assign byte_pos   = idx;
  assign last_byte  = (idx == dbfb_pkg::IDX_W'(dbfb_pkg::FRAME_BYTES - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      cnt   <= '0;
      idx   <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          if (!q_empty) begin
            sync   <= q_data.sync;
            field1 <= q_data.field1;
            field2 <= q_data.field2;
            sh1    <= q_data.field1;
            sh2    <= q_data.field2;
            r1     <= '0;
            r2     <= '0;
            cnt    <= '0;
            state  <= CALC;
          end
        end
        CALC: begin
          // both remainders shift in parallel, the short one stops early
          sh1 <= {sh1[dbfb_pkg::D1_LEN-2:0], 1'b0};
          r1  <= dbfb_pkg::bch1_step(r1, cfg.bch1_poly, sh1[dbfb_pkg::D1_LEN-1]);
          if (cnt < dbfb_pkg::STEP_W'(dbfb_pkg::BCH2_STEPS)) begin
            sh2 <= {sh2[dbfb_pkg::D2_LEN-2:0], 1'b0};
            r2  <= dbfb_pkg::bch2_step(r2, cfg.bch2_poly, sh2[dbfb_pkg::D2_LEN-1]);
          end
          if (cnt == dbfb_pkg::STEP_W'(dbfb_pkg::BCH1_STEPS - 1)) begin
            state <= FIN;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        FIN: begin
          frame <= {{dbfb_pkg::PREAMBLE_LEN{1'b1}}, sync, field1,
                    dbfb_pkg::bch1_rem(r1, cfg.bch1_poly), field2,
                    dbfb_pkg::bch2_rem(r2, cfg.bch2_poly)};
          idx   <= '0;
          state <= EMIT;
        end
        EMIT: begin
          if (pop) begin
            if (last_byte) begin
              state <= IDLE;
            end else begin
              frame <= {frame[dbfb_pkg::FRAME_BITS-9:0], 8'd0};
              idx   <= idx + 1'b1;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/distress_beacon_frame_builder_core.sv */
// channel   direction  handshake         payload
// location  in         push / full       south west lat_deg lat_min lat_sec lon_deg lon_min lon_sec
// frame     out        pop / empty       frame_byte byte_pos last_byte
// config    in         apb psel/penable  paddr pwdata prdata, pready always high
//
// a location runs through the back end in order: a load from the queue, the
// serial remainder loop (the 21-bit and 12-bit remainders run side by side),
// frame assembly, then 18 bytes, one per cycle while pop is high
// a two-entry queue sits between front and back, so push is taken while bytes drain
// a stalled pop holds the current byte; rst is synchronous and clears all control
module distress_beacon_frame_builder_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic                        south,
  input  logic                        west,
  input  logic [6:0]                  lat_deg,
  input  logic [5:0]                  lat_min,
  input  logic [5:0]                  lat_sec,
  input  logic [7:0]                  lon_deg,
  input  logic [5:0]                  lon_min,
  input  logic [5:0]                  lon_sec,
  input  logic                        pop,
  output logic                        empty,
  output logic [7:0]                  frame_byte,
  output logic [dbfb_pkg::IDX_W-1:0]  byte_pos,
  output logic                        last_byte,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dbfb_pkg::ADDR_W-1:0] paddr,
  input  logic [dbfb_pkg::DATA_W-1:0] pwdata,
  output logic [dbfb_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  dbfb_pkg::cfg_t   cfg;
  dbfb_pkg::entry_t wr_data;
  dbfb_pkg::entry_t rd_data;
  logic             q_wr;
  logic             q_full;
  logic             q_rd;
  logic             q_empty;

  dbfb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dbfb_front u_front (
    .push    (push),
    .full    (full),
    .south   (south),
    .west    (west),
    .lat_deg (lat_deg),
    .lat_min (lat_min),
    .lat_sec (lat_sec),
    .lon_deg (lon_deg),
    .lon_min (lon_min),
    .lon_sec (lon_sec),
    .cfg     (cfg),
    .q_full  (q_full),
    .q_wr    (q_wr),
    .q_data  (wr_data)
  );

  dbfb_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_data (wr_data),
    .full    (q_full),
    .rd      (q_rd),
    .rd_data (rd_data),
    .empty   (q_empty)
  );

  dbfb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_empty    (q_empty),
    .q_data     (rd_data),
    .q_rd       (q_rd),
    .pop        (pop),
    .empty      (empty),
    .frame_byte (frame_byte),
    .byte_pos   (byte_pos),
    .last_byte  (last_byte)
  );

endmodule

/* rtl/core/dbfb_checker.sv */
module dbfb_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       pop,
  input logic                       empty,
  input logic [7:0]                 frame_byte,
  input logic [dbfb_pkg::IDX_W-1:0] byte_pos,
  input logic                       last_byte
);

  // every frame opens with the bit sync ones
  a_first_byte: assert property (@(posedge clk) disable iff (rst)
    $fell(empty) |-> (byte_pos == '0) && (frame_byte == 8'hFF))
    else $error("frame does not start at byte 0 with sync ones");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (last_byte == (byte_pos == dbfb_pkg::IDX_W'(dbfb_pkg::FRAME_BYTES - 1))))
    else $error("last_byte out of step with byte_pos");

  a_index_step: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !last_byte) |=> !empty && (byte_pos == $past(byte_pos) + 1'b1))
    else $error("byte position did not advance by one");

  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && last_byte) |=> empty)
    else $error("output not empty after last byte");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty && $stable(frame_byte) && $stable(byte_pos))
    else $error("stalled byte changed");

endmodule

bind distress_beacon_frame_builder_core dbfb_checker u_dbfb_checker (
  .clk        (clk),
  .rst        (rst),
  .pop        (pop),
  .empty      (empty),
  .frame_byte (frame_byte),
  .byte_pos   (byte_pos),
  .last_byte  (last_byte)
);

/* tb/sv/dbfb_frame_checker.sv */
`timescale 1ns / 100ps

module dbfb_frame_checker
  import dbfb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic              full,
  input  logic              south,
  input  logic              west,
  input  logic [6:0]        lat_deg,
  input  logic [5:0]        lat_min,
  input  logic [5:0]        lat_sec,
  input  logic [7:0]        lon_deg,
  input  logic [5:0]        lon_min,
  input  logic [5:0]        lon_sec,
  input  logic              pop,
  input  logic              empty,
  input  logic [7:0]        frame_byte,
  input  logic [IDX_W-1:0]  byte_pos,
  input  logic              last_byte,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output int                fails,
  output int                pending
);

  typedef struct packed {
    logic [7:0]       data;
    logic [IDX_W-1:0] idx;
    logic             last;
  } beacon_byte_t;

  cfg_t                 setup;
  logic [0:FRAME_BITS-1] beacon_bits;
  beacon_byte_t         frame_bytes_due[$];
  beacon_byte_t         due_byte;

  // msb first into the frame, returns the next free position
  function automatic int place(input int pos, input logic [31:0] val, input int n);
    int i;
    for (i = n - 1; i >= 0; i--) begin
      beacon_bits[pos] = val[i];
      pos++;
    end
    return pos;
  endfunction

  // remainder in a register exactly as wide as the generator
  function automatic logic [31:0] bch_remainder(input int start, input int dlen,
                                                input logic [31:0] poly, input int plen);
    logic [31:0] mask;
    logic [31:0] r;
    int          total;
    int          i;
    mask  = (32'd1 << plen) - 32'd1;
    r     = '0;
    total = dlen + plen - 1;
    for (i = 0; i < plen; i++)
      r = ((r << 1) | 32'(beacon_bits[start + i])) & mask;
    for (i = plen; i <= total; i++) begin
      if (r[plen - 1])
        r = r ^ (poly & mask);
      if (i < total) begin
        r = (r << 1) & mask;
        if (i < dlen)
          r = r | 32'(beacon_bits[start + i]);
      end
    end
    return r & ((32'd1 << (plen - 1)) - 32'd1);
  endfunction

  function automatic void predict_frame(input logic s, input logic w,
                                        input logic [6:0] ld, input logic [5:0] lm,
                                        input logic [5:0] ls, input logic [7:0] od,
                                        input logic [5:0] om, input logic [5:0] os);
    int           p;
    int           k;
    logic         user_mode;
    logic         std_mode;
    beacon_byte_t b;
    user_mode   = (setup.protocol_mode == PROTO_USER);
    std_mode    = (setup.protocol_mode == PROTO_STD);
    beacon_bits = '0;
    p = place(0, 32'h7fff, PREAMBLE_LEN);
    p = place(p, 32'(setup.test_frame ? SYNC_TEST : SYNC_NORMAL), SYNC_LEN);
    p = place(p, 32'd1, 1);
    p = place(p, 32'(user_mode), 1);
    p = place(p, 32'(setup.country_code), 10);
    case (setup.beacon_kind)
      KIND_EPIRB: begin
        if (user_mode) void'(place(p, 32'(USER_EPIRB), 3));
        else void'(place(p, 32'(std_mode ? STD_EPIRB : NAT_EPIRB), 4));
      end
      KIND_PLB: begin
        if (user_mode) void'(place(p, 32'(USER_PLB), 3));
        else void'(place(p, 32'(std_mode ? STD_PLB : NAT_PLB), 4));
      end
      default: begin
        if (user_mode) void'(place(p, 32'(USER_ELT), 3));
        else void'(place(p, 32'(std_mode ? STD_ELT : NAT_ELT), 4));
      end
    endcase

    if (user_mode) begin
      if (setup.beacon_kind == KIND_PLB)
        void'(place(39, 32'(USER_PLB_SERIAL), 3));
      beacon_bits[84] = setup.homing_121;
    end else if (std_mode) begin
      beacon_bits[64] = s;
      beacon_bits[74] = w;
      void'(place(65, (32'(ld) << 2) + 32'(lm) / 15, 9));
      void'(place(75, (32'(od) << 2) + 32'(om) / 15, 10));
    end else begin
      beacon_bits[58] = s;
      beacon_bits[71] = w;
      p = place(59, 32'(ld), 7);
      void'(place(p, 32'(lm) / 2, 5));
      p = place(72, 32'(od), 8);
      void'(place(p, 32'(om) / 2, 5));
    end

    void'(place(85, bch_remainder(24, D1_LEN, 32'(setup.bch1_poly), BCH1_LEN),
                BCH1_LEN - 1));

    p = 106;
    if (user_mode) begin
      p = place(p, 32'(setup.internal_nav), 1);
      p = place(p, 32'(s), 1);
      p = place(p, 32'(ld), 7);
      p = place(p, 32'(lm) / 4, 4);
      p = place(p, 32'(w), 1);
      p = place(p, 32'(od), 8);
      void'(place(p, 32'(om) / 4, 4));
    end else begin
      p = place(p, 32'(FIELD2_HEAD), 4);
      p = place(p, 32'(setup.internal_nav), 1);
      p = place(p, 32'(setup.homing_121), 1);
      p = place(p, 32'd1, 1);
      if (std_mode) p = place(p, 32'(lm) % 15, 5);
      else p = place(p, 32'(lm) % 2, 2);
      p = place(p, 32'(ls) / 4, 4);
      p = place(p, 32'd1, 1);
      if (std_mode) p = place(p, 32'(om) % 15, 5);
      else p = place(p, 32'(om) % 2, 2);
      void'(place(p, 32'(os) / 4, 4));
    end

    void'(place(132, bch_remainder(106, D2_LEN, 32'(setup.bch2_poly), BCH2_LEN),
                BCH2_LEN - 1));

    for (k = 0; k < FRAME_BYTES; k++) begin
      b.data = beacon_bits[k * 8 +: 8];
      b.idx  = IDX_W'(k);
      b.last = (k == FRAME_BYTES - 1);
      frame_bytes_due.push_back(b);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      setup.protocol_mode = PROTO_RESET;
      setup.beacon_kind   = KIND_EPIRB;
      setup.country_code  = '0;
      setup.test_frame    = 1'b0;
      setup.internal_nav  = 1'b0;
      setup.homing_121    = 1'b0;
      setup.bch1_poly     = BCH1_POLY_RESET;
      setup.bch2_poly     = BCH2_POLY_RESET;
      frame_bytes_due.delete();
      fails = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[ADDR_W-1:2]))
          REG_PROTOCOL_MODE: setup.protocol_mode = pwdata[1:0];
          REG_BEACON_KIND:   setup.beacon_kind   = pwdata[1:0];
          REG_COUNTRY_CODE:  setup.country_code  = pwdata[9:0];
          REG_TEST_FRAME:    setup.test_frame    = pwdata[0];
          REG_INTERNAL_NAV:  setup.internal_nav  = pwdata[0];
          REG_HOMING_121:    setup.homing_121    = pwdata[0];
          REG_BCH1_POLY:     setup.bch1_poly     = pwdata[BCH1_LEN-1:0];
          REG_BCH2_POLY:     setup.bch2_poly     = pwdata[BCH2_LEN-1:0];
          default: ;
        endcase
      end
      if (push && !full)
        predict_frame(south, west, lat_deg, lat_min, lat_sec, lon_deg, lon_min, lon_sec);
      if (pop && !empty) begin
        if (frame_bytes_due.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected frame byte %02h position %0d at %0t",
                     frame_byte, byte_pos, $time);
        end else begin
          due_byte = frame_bytes_due.pop_front();
          if (frame_byte !== due_byte.data || byte_pos !== due_byte.idx ||
              last_byte !== due_byte.last) begin
            fails++;
            if (fails <= 10)
              $display({"mismatch at %0t: expected byte %02h position %0d last %0b, ",
                        "got %02h position %0d last %0b"},
                       $time, due_byte.data, due_byte.idx, due_byte.last,
                       frame_byte, byte_pos, last_byte);
          end
        end
      end
    end
    pending = frame_bytes_due.size();
  end

endmodule

/* tb/sv/tb_distress_beacon_frame_builder_core.sv */
`timescale 1ns / 100ps

module tb_distress_beacon_frame_builder_core;
  import dbfb_pkg::*;

  logic              clk     = 1'b0;
  logic              rst     = 1'b1;
  logic              push    = 1'b0;
  logic              south   = 1'b0;
  logic              west    = 1'b0;
  logic [6:0]        lat_deg = '0;
  logic [5:0]        lat_min = '0;
  logic [5:0]        lat_sec = '0;
  logic [7:0]        lon_deg = '0;
  logic [5:0]        lon_min = '0;
  logic [5:0]        lon_sec = '0;
  logic              pop     = 1'b0;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [DATA_W-1:0] pwdata  = '0;

  wire               full;
  wire               empty;
  wire [7:0]         frame_byte;
  wire [IDX_W-1:0]   byte_pos;
  wire               last_byte;
  wire [DATA_W-1:0]  prdata;
  wire               pready;

  int   fails;
  int   pending;
  int   send_idle_pct = 0;
  int   take_idle_pct = 0;
  int   locations_sent = 0;
  logic stall_long = 1'b0;
  logic hold_req = 1'b0;

  distress_beacon_frame_builder_core dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .south(south), .west(west),
    .lat_deg(lat_deg), .lat_min(lat_min), .lat_sec(lat_sec),
    .lon_deg(lon_deg), .lon_min(lon_min), .lon_sec(lon_sec),
    .pop(pop), .empty(empty),
    .frame_byte(frame_byte), .byte_pos(byte_pos), .last_byte(last_byte),
    .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  dbfb_frame_checker frame_check (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .south(south), .west(west),
    .lat_deg(lat_deg), .lat_min(lat_min), .lat_sec(lat_sec),
    .lon_deg(lon_deg), .lon_min(lon_min), .lon_sec(lon_sec),
    .pop(pop), .empty(empty),
    .frame_byte(frame_byte), .byte_pos(byte_pos), .last_byte(last_byte),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .fails(fails), .pending(pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      pop <= !stall_long && ($urandom_range(99) >= take_idle_pct);
    end
  end

  // long receiver hold-off so the block fills and stalls its input
  initial begin
    wait (hold_req);
    stall_long <= 1'b1;
    repeat (400) @(posedge clk);
    stall_long <= 1'b0;
  end

  initial begin
    #(64'd800_000 * 12);
    $display("Some tests failed");
    $finish;
  end

  task automatic set_pace(input int send_pct, input int take_pct);
    send_idle_pct = send_pct;
    take_idle_pct <= take_pct;
  endtask

  task automatic apb_write(input reg_idx_t idx, input logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic load_setup(input logic [1:0] mode, input logic [1:0] kind,
                            input logic [9:0] country, input logic tf, input logic nav,
                            input logic homing, input logic [BCH1_LEN-1:0] poly1,
                            input logic [BCH2_LEN-1:0] poly2);
    apb_write(REG_PROTOCOL_MODE, DATA_W'(mode));
    apb_write(REG_BEACON_KIND, DATA_W'(kind));
    apb_write(REG_COUNTRY_CODE, DATA_W'(country));
    apb_write(REG_TEST_FRAME, DATA_W'(tf));
    apb_write(REG_INTERNAL_NAV, DATA_W'(nav));
    apb_write(REG_HOMING_121, DATA_W'(homing));
    apb_write(REG_BCH1_POLY, DATA_W'(poly1));
    apb_write(REG_BCH2_POLY, DATA_W'(poly2));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_location(input logic s, input logic w,
                               input logic [6:0] ld, input logic [5:0] lm,
                               input logic [5:0] ls, input logic [7:0] od,
                               input logic [5:0] om, input logic [5:0] os);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    south   <= s;
    west    <= w;
    lat_deg <= ld;
    lat_min <= lm;
    lat_sec <= ls;
    lon_deg <= od;
    lon_min <= om;
    lon_sec <= os;
    @(posedge clk);
    while (full) @(posedge clk);
    locations_sent++;
  endtask

  // zeros, all ones, in-range maximum, or random content
  task automatic send_pattern(input int pick);
    logic wide;
    wide = ($urandom_range(9) < 3);
    case (pick)
      0: send_location(1'b0, 1'b0, 7'd0, 6'd0, 6'd0, 8'd0, 6'd0, 6'd0);
      1: send_location(1'b1, 1'b1, 7'h7f, 6'h3f, 6'h3f, 8'hff, 6'h3f, 6'h3f);
      2: send_location(1'b0, 1'b1, 7'd90, 6'd59, 6'd59, 8'd180, 6'd59, 6'd59);
      default: begin
        if (wide)
          send_location(1'($urandom), 1'($urandom), 7'($urandom), 6'($urandom),
                        6'($urandom), 8'($urandom), 6'($urandom), 6'($urandom));
        else
          send_location(1'($urandom_range(1)), 1'($urandom_range(1)),
                        7'($urandom_range(90)), 6'($urandom_range(59)),
                        6'($urandom_range(59)), 8'($urandom_range(180)),
                        6'($urandom_range(59)), 6'($urandom_range(59)));
      end
    endcase
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  initial begin : stimulus
    int                  ph;
    int                  m;
    int                  k;
    int                  n;
    logic [BCH1_LEN-1:0] poly1;
    logic [BCH2_LEN-1:0] poly2;
    logic [9:0]          country;

    set_pace(31, 66);
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset register values first
    for (n = 0; n < 3; n++)
      send_pattern(n);
    wait_drained();

    for (m = 0; m < 4; m++) begin
      for (k = 0; k < 4; k++) begin
        load_setup(2'(m), 2'(k), 10'($urandom_range(1023)), k[0], m[0], k[1] ^ m[0],
                   BCH1_POLY_RESET, BCH2_POLY_RESET);
        send_pattern((m * 4 + k) % 4);
        wait_drained();
      end
    end

    for (ph = 0; ph < 12; ph++) begin
      if (ph < 4) set_pace(31, 66);
      else if (ph < 8) set_pace(66, 31);
      else set_pace(0, 0);
      case (ph % 4)
        0: begin
          poly1 = BCH1_POLY_RESET;
          poly2 = BCH2_POLY_RESET;
        end
        1: begin
          poly1 = '0;
          poly2 = '0;
        end
        2: begin
          poly1 = '1;
          poly2 = '1;
        end
        default: begin
          poly1 = BCH1_LEN'($urandom);
          poly2 = BCH2_LEN'($urandom);
          poly1[BCH1_LEN-1] = 1'($urandom_range(1));
          poly2[BCH2_LEN-1] = 1'($urandom_range(1));
        end
      endcase
      if (ph == 1) country = '0;
      else if (ph == 2) country = '1;
      else country = 10'($urandom_range(1023));
      load_setup(2'($urandom_range(3)), 2'($urandom_range(3)), country,
                 1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                 poly1, poly2);
      if (ph == 8) hold_req = 1'b1;
      for (n = 0; n < 32; n++) begin
        if (ph == 5 && n == 16) wait_drained();
        send_pattern(3);
      end
      wait_drained();
    end

    set_pace(0, 0);
    repeat (150) @(posedge clk);
    @(negedge clk);
    $display("%0d locations framed across all protocol modes, beacon kinds and sync patterns",
             locations_sent);
    $display("generators at reset, zero, all ones and random, with input back-pressure");
    if (fails == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
